/* rtl/core/etg_pkg.sv */
package etg_pkg;

    // fixed field widths
    localparam int LEVEL_W   = 32;
    localparam int DUR_W     = 16;
    localparam int MODE_W    = 2;
    localparam int FUNC_W    = 2;
    localparam int NOW_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // defaults for top-level parameters
    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam int TIME_WIDTH_DEF      = 32;

    localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE  = 2'd0,
        FUNC_END     = 2'd1,
        FUNC_RESTART = 2'd2
    } func_code_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_CUBIC  = 2'd1,
        MODE_QUAD   = 2'd2
    } mode_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_START    = 2'd1,
        CFG_FINAL    = 2'd2,
        CFG_DURATION = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NOW_W-1:0]  now_ms;
    } cmd_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      finished;
    } res_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/etg_div.sv */
module etg_div
    import etg_pkg::*;
#(
    parameter int FRAC_BITS = RATIO_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctl_t             ctl,
    input  logic [DUR_W-1:0]     num,
    input  logic [DUR_W-1:0]     den,
    output div_stat_t            stat,
    output logic [FRAC_BITS-1:0] quot
);

    // restoring division of num * 2^FRAC_BITS by den, num < den, one bit per cycle
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DUR_W-1:0]     rem_reg, rem_next;
    logic [DUR_W-1:0]     den_reg, den_next;
    logic [FRAC_BITS-1:0] quot_reg, quot_next;

    logic [DUR_W:0] rem2;
    logic [DUR_W:0] diff;
    logic           ge;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, den_reg};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        if (ctl.start)
        begin
            rem_next   = num;
            den_next   = den;
            count_next = CNT_W'(FRAC_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[DUR_W-1:0] : rem2[DUR_W-1:0];
            quot_next  = {quot_reg[FRAC_BITS-2:0], ge};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

/* rtl/core/easing_transition_generator.sv */
// Easing transition generator: moves one value from start_level to final_level over
// duration_ms milliseconds along a linear, cubic in-out or quadratic in-out curve, and
// answers every command item with exactly one result item (level, finished). An update
// command evaluates the curve at elapsed/duration; the first update after reset or a
// restart latches now_ms as the start time and returns start_level. Elapsed time is
// saturated at the duration, and once the value is less than 2 units from final_level
// the block snaps to final_level and reports finished. Force end and restart, updates
// after the end, and unknown codes load their result at the edge they are taken. For
// an update that evaluates the curve, the serial ratio divider resolves one quotient
// bit per cycle, and a single shared multiplier then forms the square, the cube and the
// scaled change in turn; the quadratic curve skips the cube and the linear curve uses
// the multiplier only for the scaled change. Once elapsed time has reached the duration
// the divider is skipped. A new command is taken only once the sequencer is idle and
// the previous result slot is free or being drained.
// Configuration writes are expected only while no update is in flight.
module easing_transition_generator
    import etg_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
    parameter int TIME_WIDTH      = TIME_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int F      = RATIO_FRAC_BITS;
    localparam int MUL_AW = LEVEL_W + 1;          // magnitude of the change
    localparam int MUL_BW = F + 1;                // weight in Q1.F, up to one
    localparam int PROD_W = MUL_AW + MUL_BW;

    localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF = ONE >> 1;

    // sequencer, one-hot
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PREP  = 10'b0000000010,
        ST_DIV   = 10'b0000000100,
        ST_SEL   = 10'b0000001000,
        ST_SQ    = 10'b0000010000,
        ST_CUBE  = 10'b0000100000,
        ST_WGT   = 10'b0001000000,
        ST_SCALE = 10'b0010000000,
        ST_LVL   = 10'b0100000000,
        ST_END   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic signed [LEVEL_W-1:0] start_reg, start_next;
    logic signed [LEVEL_W-1:0] final_reg, final_next;
    logic [DUR_W-1:0]          dur_reg, dur_next;

    // transition state
    logic                      began_reg, began_next;
    logic [TIME_WIDTH-1:0]     begin_time_reg, begin_time_next;
    logic                      done_reg, done_next;
    logic signed [LEVEL_W-1:0] present_reg, present_next;

    // result slot
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    // datapath registers
    logic [TIME_WIDTH-1:0]     elapsed_reg, elapsed_next;
    logic [F:0]                r_reg, r_next;
    logic [F-1:0]              x_reg, x_next;
    logic                      r_lo_reg, r_lo_next;
    logic [F:0]                w_reg, w_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [LEVEL_W-1:0] lvl_reg, lvl_next;

    // change from start to final, refreshed every cycle from the config registers
    logic signed [LEVEL_W:0]   diff_reg;
    logic [LEVEL_W:0]          mag_reg;
    logic                      neg_reg;
    logic                      up_reg;

    logic                  out_free;
    logic                  accept;
    logic [TIME_WIDTH-1:0] now_t;
    logic [DUR_W-1:0]      dur_eff;
    logic                  emit;

    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;

    logic [F:0]                c4;
    logic [F:0]                t_quad;
    logic [LEVEL_W:0]          p_mag;
    logic signed [LEVEL_W+1:0] q_signed;
    logic signed [LEVEL_W+1:0] lvl_wide;
    logic signed [LEVEL_W:0]   gap;

    div_ctl_t         div_ctl;
    div_stat_t        div_stat;
    logic [F-1:0]     div_quot;

    // serial ratio divider
    etg_div #(
        .FRAC_BITS (F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (elapsed_reg[DUR_W-1:0]),
        .den   (dur_eff),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign now_t     = cmd.now_ms[TIME_WIDTH-1:0];
    // zero duration behaves as one ms
    assign dur_eff   = (dur_reg == '0) ? DUR_W'(1) : dur_reg;

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (1'b1)
            state_reg[4]:   // square of the folded ratio
            begin
                mul_a = MUL_AW'(x_reg);
                mul_b = MUL_BW'(x_reg);
            end
            state_reg[5]:   // square times ratio for the cube
            begin
                mul_a = MUL_AW'(prod_reg[2*F-1:F]);
                mul_b = MUL_BW'(x_reg);
            end
            state_reg[7]:   // change magnitude times weight
            begin
                mul_a = mag_reg;
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // weight pieces from the product register
    assign c4     = {1'b0, prod_reg[2*F-3:F], 2'b00};
    assign t_quad = {1'b0, prod_reg[2*F-2:F-1]};

    // level from the scaled change
    assign p_mag    = prod_reg[F+LEVEL_W:F];
    assign q_signed = neg_reg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
    assign lvl_wide = (LEVEL_W+2)'(start_reg) + q_signed;

    // distance still to go toward final
    assign gap = up_reg ? ((LEVEL_W+1)'(final_reg) - (LEVEL_W+1)'(lvl_reg))
                        : ((LEVEL_W+1)'(lvl_reg) - (LEVEL_W+1)'(final_reg));

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        start_next      = start_reg;
        final_next      = final_reg;
        dur_next        = dur_reg;
        began_next      = began_reg;
        begin_time_next = begin_time_reg;
        done_next       = done_reg;
        present_next    = present_reg;
        elapsed_next    = elapsed_reg;
        r_next          = r_reg;
        x_next          = x_reg;
        r_lo_next       = r_lo_reg;
        w_next          = w_reg;
        lvl_next        = lvl_reg;
        div_ctl.start   = 1'b0;
        emit            = 1'b0;

        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:     mode_next  = cfg_data[MODE_W-1:0];
                CFG_START:    start_next = $signed(cfg_data[LEVEL_W-1:0]);
                CFG_FINAL:    final_next = $signed(cfg_data[LEVEL_W-1:0]);
                CFG_DURATION: dur_next   = cfg_data[DUR_W-1:0];
                default:      mode_next  = mode_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        FUNC_UPDATE:
                        begin
                            if (done_reg)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                began_next = 1'b1;
                                if (!began_reg)
                                begin
                                    begin_time_next = now_t;
                                    elapsed_next    = '0;
                                end
                                else
                                begin
                                    elapsed_next = now_t - begin_time_reg;
                                end
                                state_next = ST_PREP;
                            end
                        end
                        FUNC_END:
                        begin
                            present_next = final_reg;
                            done_next    = 1'b1;
                            emit         = 1'b1;
                        end
                        FUNC_RESTART:
                        begin
                            began_next      = 1'b0;
                            begin_time_next = '0;
                            done_next       = 1'b0;
                            present_next    = start_reg;
                            emit            = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                // saturated elapsed gives a ratio of exactly one
                if (elapsed_reg >= TIME_WIDTH'(dur_eff))
                begin
                    r_next     = ONE;
                    state_next = ST_SEL;
                end
                else
                begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    r_next     = {1'b0, div_quot};
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                // fold the upper half of the curve onto the lower half
                r_lo_next = (r_reg < HALF);
                x_next    = (r_reg < HALF) ? r_reg[F-1:0] : F'(ONE - r_reg);
                unique case (mode_reg)
                    MODE_CUBIC: state_next = ST_SQ;
                    MODE_QUAD:  state_next = ST_SQ;
                    default:
                    begin
                        w_next     = r_reg;
                        state_next = ST_SCALE;
                    end
                endcase
            end
            ST_SQ:
            begin
                state_next = (mode_reg == MODE_CUBIC) ? ST_CUBE : ST_WGT;
            end
            ST_CUBE:
            begin
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                if (mode_reg == MODE_CUBIC)
                begin
                    w_next = r_lo_reg ? c4 : (ONE - c4);
                end
                else
                begin
                    w_next = r_lo_reg ? t_quad : (ONE - t_quad);
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                lvl_next   = lvl_wide[LEVEL_W-1:0];
                state_next = ST_END;
            end
            ST_END:
            begin
                if (out_free)
                begin
                    if (gap < (LEVEL_W+1)'(2))
                    begin
                        present_next = final_reg;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        present_next = lvl_reg;
                    end
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result slot
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (emit)
        begin
            res_valid_next    = 1'b1;
            res_next.level    = present_next;
            res_next.finished = done_next;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_LINEAR;
            start_reg      <= '0;
            final_reg      <= '0;
            dur_reg        <= DUR_RESET;
            began_reg      <= 1'b0;
            begin_time_reg <= '0;
            done_reg       <= 1'b0;
            present_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            start_reg      <= start_next;
            final_reg      <= final_next;
            dur_reg        <= dur_next;
            began_reg      <= began_next;
            begin_time_reg <= begin_time_next;
            done_reg       <= done_next;
            present_reg    <= present_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        elapsed_reg <= elapsed_next;
        r_reg       <= r_next;
        x_reg       <= x_next;
        r_lo_reg    <= r_lo_next;
        w_reg       <= w_next;
        lvl_reg     <= lvl_next;
        if (state_reg == ST_SQ || state_reg == ST_CUBE || state_reg == ST_SCALE)
        begin
            prod_reg <= prod_next;
        end
        // change magnitude and direction, registered from diff_reg
        diff_reg <= (LEVEL_W+1)'(final_reg) - (LEVEL_W+1)'(start_reg);
        mag_reg  <= diff_reg[LEVEL_W] ? (LEVEL_W+1)'(-diff_reg) : (LEVEL_W+1)'(diff_reg);
        neg_reg  <= diff_reg[LEVEL_W];
        up_reg   <= !diff_reg[LEVEL_W] && (diff_reg != '0);
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    // divider runs only while the sequencer waits on it
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    // weight never exceeds one when it is applied
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (w_reg <= ONE))
        else $error("weight above one");

    // finishing an update always loads the result slot
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_END) && out_free) |=> res_valid_reg)
        else $error("update finished without result");

    // no command is taken while an update is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> cmd_stall)
        else $error("command taken during update");
`endif

endmodule
